// ----- rtl/command_word_splitter_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the command word splitter
// Each macro checks a property on the rising edge of clk, idle during rst.
// ---------------------------------------------------------------------------
`ifndef COMMAND_WORD_SPLITTER_ASSERT_SVH
`define COMMAND_WORD_SPLITTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define CWS_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("command_word_splitter: same-cycle check failed");

// Next-cycle implication.
`define CWS_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("command_word_splitter: next-cycle check failed");

`else

`define CWS_ASSERT_IMP(lbl, pre, post)
`define CWS_ASSERT_NXT(lbl, pre, post)

`endif

`endif

// ----- rtl/cws_pkg.sv -----
// ---------------------------------------------------------------------------
// Command word splitter package
// Shared constants, result kinds and the result bundle type.
// ---------------------------------------------------------------------------
package cws_pkg;

  localparam int ARG_COUNT_MAX = 255;

  // The count field is eight bits wide, so the cap never exceeds 255.
  localparam logic [7:0] COUNT_CAP = 8'((ARG_COUNT_MAX > 255) ? 255 : ARG_COUNT_MAX);

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_ARG_END = 2'd1,
    KIND_CMD_END = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } quote_t;

  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic [7:0] char_out;
    kind_t      kind;
    logic [7:0] arg_count;
  } result_t;

  // Up to three results per item: a byte or argument end from the character,
  // an argument end forced by the command end, and the command end itself.
  typedef struct packed {
    logic [2:0]       vld;
    result_t [2:0]    res;
  } bundle_t;

endpackage

// ----- rtl/cws_in_if.sv -----
// ---------------------------------------------------------------------------
// Command byte channel
// Valid/ready channel carrying one command byte and its flags per item.
// ---------------------------------------------------------------------------
interface cws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       has_char;
  logic       end_of_command;

  modport source(output valid, output char_in, output has_char,
                 output end_of_command, input ready);
  modport sink(input valid, input char_in, input has_char,
               input end_of_command, output ready);
endinterface

// ----- rtl/cws_out_if.sv -----
// ---------------------------------------------------------------------------
// Argument result channel
// Valid/ready channel carrying one argument byte or marker per item.
// ---------------------------------------------------------------------------
interface cws_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic [1:0] kind;
  logic [7:0] arg_count;
  logic       last_of_run;

  modport source(output valid, output char_out, output kind, output arg_count,
                 output last_of_run, input ready);
  modport sink(input valid, input char_out, input kind, input arg_count,
               input last_of_run, output ready);
endinterface

// ----- rtl/cws_parse.sv -----
// ---------------------------------------------------------------------------
// Command word splitter parser
// Holds the quoting and escape state and turns one item into a result bundle.
// ---------------------------------------------------------------------------
module cws_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       char_in,
  input  logic             has_char,
  input  logic             end_of_command,
  output cws_pkg::bundle_t bundle
);

  logic            escape_pending;
  logic            escape_pending_next;
  cws_pkg::quote_t quote_mode;
  cws_pkg::quote_t quote_mode_next;
  logic            arg_open;
  logic            arg_open_next;
  logic [7:0]      args_seen;
  logic [7:0]      args_seen_next;

  logic            r0_vld;
  cws_pkg::kind_t  r0_kind;
  logic [7:0]      r0_char;
  logic [7:0]      cnt_a;
  logic            r1_vld;
  logic [7:0]      cnt_b;

  function automatic logic [7:0] sat_inc(input logic [7:0] cnt);
    return (cnt < cws_pkg::COUNT_CAP) ? cnt + 8'd1 : cnt;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      cws_pkg::CH_N: r = 8'd10;
      cws_pkg::CH_R: r = 8'd13;
      cws_pkg::CH_T: r = 8'd9;
      cws_pkg::CH_F: r = 8'd12;
      cws_pkg::CH_V: r = 8'd11;
      cws_pkg::CH_A: r = 8'd7;
      cws_pkg::CH_B: r = 8'd8;
      default:       r = c;
    endcase
    return r;
  endfunction

  always_comb begin
    escape_pending_next = escape_pending;
    quote_mode_next     = quote_mode;
    arg_open_next       = arg_open;
    cnt_a               = args_seen;
    r0_vld              = 1'b0;
    r0_kind             = cws_pkg::KIND_CHAR;
    r0_char             = 8'd0;

    // A zero byte is ignored just like an absent one.
    if (has_char && (char_in != 8'd0)) begin
      if (escape_pending) begin
        escape_pending_next = 1'b0;
        arg_open_next       = 1'b1;
        r0_vld              = 1'b1;
        r0_char = (quote_mode == cws_pkg::Q_DOUBLE) ? unescape(char_in) : char_in;
      end else if (((quote_mode == cws_pkg::Q_SINGLE) && (char_in == cws_pkg::CH_SQUOTE)) ||
                   ((quote_mode == cws_pkg::Q_DOUBLE) && (char_in == cws_pkg::CH_DQUOTE))) begin
        quote_mode_next = cws_pkg::Q_NONE;
      end else if ((quote_mode != cws_pkg::Q_SINGLE) && (char_in == cws_pkg::CH_BSLASH)) begin
        escape_pending_next = 1'b1;
      end else if ((quote_mode == cws_pkg::Q_NONE) && (char_in == cws_pkg::CH_DQUOTE)) begin
        quote_mode_next = cws_pkg::Q_DOUBLE;
      end else if ((quote_mode == cws_pkg::Q_NONE) && (char_in == cws_pkg::CH_SQUOTE)) begin
        quote_mode_next = cws_pkg::Q_SINGLE;
      end else if ((quote_mode == cws_pkg::Q_NONE) && (char_in == cws_pkg::CH_SPACE)) begin
        if (arg_open) begin
          arg_open_next = 1'b0;
          cnt_a         = sat_inc(args_seen);
          r0_vld        = 1'b1;
          r0_kind       = cws_pkg::KIND_ARG_END;
        end
      end else begin
        arg_open_next = 1'b1;
        r0_vld        = 1'b1;
        r0_char       = char_in;
      end
    end

    r1_vld = end_of_command && arg_open_next;
    cnt_b  = r1_vld ? sat_inc(cnt_a) : cnt_a;

    bundle.vld                = {end_of_command, r1_vld, r0_vld};
    bundle.res[0].char_out    = r0_char;
    bundle.res[0].kind        = r0_kind;
    bundle.res[0].arg_count   = cnt_a;
    bundle.res[1].char_out    = 8'd0;
    bundle.res[1].kind        = cws_pkg::KIND_ARG_END;
    bundle.res[1].arg_count   = cnt_b;
    bundle.res[2].char_out    = 8'd0;
    bundle.res[2].kind        = cws_pkg::KIND_CMD_END;
    bundle.res[2].arg_count   = cnt_b;

    // The command end returns every piece of state to its reset value.
    if (end_of_command) begin
      escape_pending_next = 1'b0;
      quote_mode_next     = cws_pkg::Q_NONE;
      arg_open_next       = 1'b0;
      args_seen_next      = 8'd0;
    end else begin
      args_seen_next      = cnt_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      quote_mode     <= cws_pkg::Q_NONE;
      arg_open       <= 1'b0;
      args_seen      <= 8'd0;
    end else if (take) begin
      escape_pending <= escape_pending_next;
      quote_mode     <= quote_mode_next;
      arg_open       <= arg_open_next;
      args_seen      <= args_seen_next;
    end
  end

endmodule

// ----- rtl/cws_drain.sv -----
// ---------------------------------------------------------------------------
// Command word splitter result buffer
// Registers one result bundle and hands its results out one per cycle while out_ready is high.
// ---------------------------------------------------------------------------
module cws_drain (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  cws_pkg::bundle_t bundle,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output cws_pkg::result_t out_res,
  output logic             out_last
);

  logic [2:0]             pend;
  cws_pkg::result_t [2:0] slots;
  logic [2:0]             first;
  logic [2:0]             rest;
  logic                   done;

  // Results leave in bundle order, so the lowest pending slot goes next.
  assign first     = pend & (~pend + 3'd1);
  assign rest      = pend & ~first;
  assign out_valid = |pend;
  assign done      = out_valid && out_ready;
  assign out_last  = (rest == 3'd0);
  assign room      = (pend == 3'd0) || ((rest == 3'd0) && out_ready);

  always_comb begin
    if (first[0]) begin
      out_res = slots[0];
    end else if (first[1]) begin
      out_res = slots[1];
    end else begin
      out_res = slots[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 3'd0;
    end else if (take) begin
      pend <= bundle.vld;
    end else if (done) begin
      pend <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slots <= bundle.res;
    end
  end

endmodule

// ----- rtl/command_word_splitter.sv -----
// ---------------------------------------------------------------------------
// Command word splitter
// Splits a command line, one byte per item, into shell-style arguments.
// ---------------------------------------------------------------------------
// One command byte is accepted per clock cycle as long as each item causes at
// most one result and word.ready is high. An item that causes more results
// (at most three: a byte or an argument end, an argument end forced by the
// command end, and the command end) holds the result buffer until all leave,
// one result per cycle while word.ready is high; the next item is taken in
// the cycle its last result leaves. Items that cause no result leave the
// buffer free. Results appear from the cycle after their item is accepted.
module command_word_splitter (
  input  logic      clk,
  input  logic      rst,
  cws_in_if.sink    cmd,
  cws_out_if.source word
);

  `include "command_word_splitter_assert.svh"

  cws_pkg::bundle_t bundle;
  cws_pkg::result_t out_res;
  logic             take;
  logic             room;
  logic             out_valid;
  logic             out_last;

  assign take      = cmd.valid && room;
  assign cmd.ready = room;

  cws_parse u_parse (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .char_in        (cmd.char_in),
    .has_char       (cmd.has_char),
    .end_of_command (cmd.end_of_command),
    .bundle         (bundle)
  );

  cws_drain u_drain (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .bundle    (bundle),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (word.ready),
    .out_res   (out_res),
    .out_last  (out_last)
  );

  assign word.valid       = out_valid;
  assign word.char_out    = out_res.char_out;
  assign word.kind        = out_res.kind;
  assign word.arg_count   = out_res.arg_count;
  assign word.last_of_run = out_last;

  // The command end is always the final result of its item.
  `CWS_ASSERT_IMP(a_cmd_end_last, word.valid && (word.kind == cws_pkg::KIND_CMD_END), word.last_of_run)
  // Markers carry no byte.
  `CWS_ASSERT_IMP(a_marker_zero, word.valid && (word.kind != cws_pkg::KIND_CHAR), word.char_out == 8'd0)
  // An argument end has always counted at least that argument.
  `CWS_ASSERT_IMP(a_arg_end_count, word.valid && (word.kind == cws_pkg::KIND_ARG_END), word.arg_count != 8'd0)
  // A result that is not the last of its item keeps the input stalled.
  `CWS_ASSERT_IMP(a_hold_input, word.valid && !word.last_of_run, !cmd.ready)

endmodule
